// ----- sv/pflr_pkg.sv -----
// Package for the page frame lookup block: field widths, defaults, the
// lookup status struct and the LFSR and residue helpers.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package pflr_pkg;

  // Field widths of the channels.
  localparam int INDEX_BITS    = 20;
  localparam int SLOT_OUT_BITS = 2;
  localparam int FETCH_BITS    = 13;
  localparam int COUNT_BITS    = 32;

  // Page geometry: PAGE_ELEMENTS is a power of two, so the split is a shift and a mask.
  localparam int PAGE_ELEMENTS = 128;
  localparam int OFFSET_BITS   = $clog2(PAGE_ELEMENTS);

  // Defaults for the top level parameters.
  localparam int FRAME_COUNT_DEF      = 4;
  localparam int PAGE_NUMBER_BITS_DEF = 13;

  // Victim LFSR.
  localparam int              LFSR_BITS = 16;
  localparam logic [LFSR_BITS-1:0] LFSR_SEED = 16'hACE1;

  // Residues modulo a frame count of at most 16 fit in four bits.
  localparam int RES_BITS = 4;

  typedef logic [255:0][RES_BITS-1:0] res_table_t;

  // Status of one lookup, passed from the frame table to the top level.
  typedef struct packed {
    logic hit;
    logic use_victim;
  } lookup_t;

  // One Fibonacci step, taps 16, 14, 13 and 11, shifting right.
  function automatic logic [LFSR_BITS-1:0] lfsr_step(input logic [LFSR_BITS-1:0] v);
    logic fb;
    fb = v[0] ^ v[2] ^ v[3] ^ v[5];
    return {fb, v[LFSR_BITS-1:1]};
  endfunction

  // Table of k mod n for k from 0 to 255, built by counting.
  function automatic res_table_t residue_table(input int n);
    res_table_t          tbl;
    logic [RES_BITS-1:0] r;
    r = '0;
    for (int k = 0; k < 256; k++) begin
      tbl[k] = r;
      r = (r == RES_BITS'(n - 1)) ? '0 : r + RES_BITS'(1);
    end
    return tbl;
  endfunction

  // 256 mod n, taken from the last table entry.
  function automatic logic [RES_BITS-1:0] residue_256(input int n);
    res_table_t tbl;
    tbl = residue_table(n);
    return (tbl[255] == RES_BITS'(n - 1)) ? '0 : tbl[255] + RES_BITS'(1);
  endfunction

  // A 16-bit value modulo n: fold the two bytes, then one more table read.
  // The fold is at most 15 * 15 + 15, so it fits in eight bits.
  function automatic logic [RES_BITS-1:0] residue16(input logic [LFSR_BITS-1:0] v,
                                                    input res_table_t tbl,
                                                    input logic [RES_BITS-1:0] t256);
    logic [RES_BITS-1:0] r_hi;
    logic [RES_BITS-1:0] r_lo;
    logic [7:0]          fold;
    r_hi = tbl[v[15:8]];
    r_lo = tbl[v[7:0]];
    fold = 8'(r_hi) * 8'(t256) + 8'(r_lo);
    return tbl[fold];
  endfunction

endpackage

`default_nettype wire

// ----- sv/pflr_if.sv -----
// Valid/ready channel interfaces for the request and result words.
// Depends on pflr_pkg for the field widths.
`default_nettype none

interface pflr_req_if;
  logic                           valid;
  logic                           ready;
  logic [pflr_pkg::INDEX_BITS-1:0] element_index;

  modport source (output valid, output element_index, input ready);
  modport sink   (input valid, input element_index, output ready);
endinterface

interface pflr_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [pflr_pkg::SLOT_OUT_BITS-1:0] frame_slot;
  logic [pflr_pkg::OFFSET_BITS-1:0]   page_offset;
  logic                              was_hit;
  logic [pflr_pkg::FETCH_BITS-1:0]    fetch_page;
  logic [pflr_pkg::COUNT_BITS-1:0]    hit_total;
  logic [pflr_pkg::COUNT_BITS-1:0]    fault_total;

  modport source (output valid, output frame_slot, output page_offset, output was_hit,
                  output fetch_page, output hit_total, output fault_total, input ready);
  modport sink   (input valid, input frame_slot, input page_offset, input was_hit,
                  input fetch_page, input hit_total, input fault_total, output ready);
endinterface

`default_nettype wire

// ----- sv/pflr_frame_table.sv -----
// Frame table: page tags and loaded flags, parallel compare and slot pick.
// Depends on pflr_pkg for the lookup status struct.
`default_nettype none

module pflr_frame_table #(
  parameter int FRAME_COUNT      = pflr_pkg::FRAME_COUNT_DEF,
  parameter int PAGE_NUMBER_BITS = pflr_pkg::PAGE_NUMBER_BITS_DEF,
  localparam int FW              = $clog2(FRAME_COUNT)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        update,
  input  wire logic [PAGE_NUMBER_BITS-1:0] page,
  input  wire logic [FW-1:0]               victim_slot,
  output pflr_pkg::lookup_t                lookup,
  output logic      [FW-1:0]               slot,
  output logic      [FRAME_COUNT-1:0]      valid_mask
);

  logic [FRAME_COUNT-1:0]      slot_valid;
  logic [PAGE_NUMBER_BITS-1:0] slot_page [FRAME_COUNT];
  logic [FRAME_COUNT-1:0]      match;
  logic [FW-1:0]               match_idx;
  logic [FW-1:0]               empty_idx;
  logic                        full;

  // Only loaded frames take part in the compare.
  always_comb begin
    for (int i = 0; i < FRAME_COUNT; i++) begin
      match[i] = slot_valid[i] && (slot_page[i] == page);
    end
  end

  // Lowest-numbered matching frame and lowest-numbered empty frame.
  always_comb begin
    match_idx = '0;
    empty_idx = '0;
    for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
      if (match[i]) begin
        match_idx = FW'(i);
      end
      if (!slot_valid[i]) begin
        empty_idx = FW'(i);
      end
    end
  end

  assign full              = &slot_valid;
  assign lookup.hit        = |match;
  assign lookup.use_victim = !lookup.hit && full;
  assign valid_mask        = slot_valid;

  always_comb begin
    if (lookup.hit) begin
      slot = match_idx;
    end else if (full) begin
      slot = victim_slot;
    end else begin
      slot = empty_idx;
    end
  end

  // Loaded flags are control state and clear on reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (update && !lookup.hit) begin
      slot_valid[slot] <= 1'b1;
    end
  end

  // Page tags are only read behind a loaded flag, so they need no reset.
  always_ff @(posedge clk) begin
    if (update && !lookup.hit) begin
      slot_page[slot] <= page;
    end
  end

endmodule

`default_nettype wire

// ----- sv/pflr_victim_pick.sv -----
// Victim choice: 16-bit LFSR and its residue modulo the frame count.
// Depends on pflr_pkg for the LFSR step and the residue tables.
`default_nettype none

module pflr_victim_pick #(
  parameter int FRAME_COUNT = pflr_pkg::FRAME_COUNT_DEF,
  localparam int FW         = $clog2(FRAME_COUNT)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  output logic      [FW-1:0] slot
);

  localparam pflr_pkg::res_table_t RES_TBL = pflr_pkg::residue_table(FRAME_COUNT);
  localparam logic [pflr_pkg::RES_BITS-1:0] RES_256 = pflr_pkg::residue_256(FRAME_COUNT);
  localparam logic [pflr_pkg::RES_BITS-1:0] RES_SEED =
    pflr_pkg::residue16(pflr_pkg::LFSR_SEED, RES_TBL, RES_256);

  logic [pflr_pkg::LFSR_BITS-1:0] lfsr;
  logic [pflr_pkg::LFSR_BITS-1:0] lfsr_next;
  logic [pflr_pkg::RES_BITS-1:0]  res;

  assign lfsr_next = pflr_pkg::lfsr_step(lfsr);

  // The residue is kept a step ahead, so the lookup path sees a register.
  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= pflr_pkg::LFSR_SEED;
      res  <= RES_SEED;
    end else if (step) begin
      lfsr <= lfsr_next;
      res  <= pflr_pkg::residue16(lfsr_next, RES_TBL, RES_256);
    end
  end

  assign slot = FW'(res);

endmodule

`default_nettype wire

// ----- sv/pflr_sat_counter.sv -----
// Saturating event counter with its next value exposed.
// Depends on pflr_pkg for the counter width.
`default_nettype none

module pflr_sat_counter (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            inc,
  output logic [pflr_pkg::COUNT_BITS-1:0]      count,
  output logic [pflr_pkg::COUNT_BITS-1:0]      count_next
);

  // Hold at all ones once reached.
  always_comb begin
    if (inc && (count != '1)) begin
      count_next = count + pflr_pkg::COUNT_BITS'(1);
    end else begin
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/page_frame_lookup_random_replace.sv -----
// Top level of the page frame lookup with random replacement.
// Depends on pflr_pkg, pflr_if, pflr_frame_table, pflr_victim_pick and pflr_sat_counter.
//
//   channel | direction | word fields
//   --------+-----------+----------------------------------------------------------
//   req     | in        | element_index
//   rsp     | out       | frame_slot, page_offset, was_hit, fetch_page,
//           |           | hit_total, fault_total
//
// A word is registered on entry and its result word in the result register after it;
// one word is accepted every cycle unless a result word is not taken.
// The frame compare, slot pick and counter update happen between those two registers.
// Reset is synchronous and clears the loaded flags, counters, LFSR and both valids.
// When a result word is not taken and the entry register is full, the entry register
// holds and req.ready falls.
`default_nettype none

module page_frame_lookup_random_replace #(
  parameter int FRAME_COUNT      = pflr_pkg::FRAME_COUNT_DEF,
  parameter int PAGE_NUMBER_BITS = pflr_pkg::PAGE_NUMBER_BITS_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  pflr_req_if.sink   req,
  pflr_rsp_if.source rsp
);

  localparam int FW = $clog2(FRAME_COUNT);

  logic                              s1_valid;
  logic [pflr_pkg::INDEX_BITS-1:0]   s1_index;
  logic                              advance;
  logic                              take_in;
  logic [PAGE_NUMBER_BITS-1:0]       page;
  logic [pflr_pkg::OFFSET_BITS-1:0]  offset;
  pflr_pkg::lookup_t                 lookup;
  logic [FW-1:0]                     slot;
  logic [FW-1:0]                     victim_slot;
  logic [FRAME_COUNT-1:0]            valid_mask;
  logic [pflr_pkg::COUNT_BITS-1:0]   hit_count;
  logic [pflr_pkg::COUNT_BITS-1:0]   hit_count_next;
  logic [pflr_pkg::COUNT_BITS-1:0]   fault_count;
  logic [pflr_pkg::COUNT_BITS-1:0]   fault_count_next;

  logic                              out_valid;
  logic [pflr_pkg::SLOT_OUT_BITS-1:0] out_slot;
  logic [pflr_pkg::OFFSET_BITS-1:0]  out_offset;
  logic                              out_hit;
  logic [pflr_pkg::FETCH_BITS-1:0]   out_fetch;
  logic [pflr_pkg::COUNT_BITS-1:0]   out_hits;
  logic [pflr_pkg::COUNT_BITS-1:0]   out_faults;

  // Handshake: the entry word moves on whenever the result register is free.
  assign advance   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || advance;
  assign take_in   = req.valid && req.ready;

  // Entry register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take_in) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      s1_index <= req.element_index;
    end
  end

  // Split the index into page number and offset within the page.
  assign page   = PAGE_NUMBER_BITS'(s1_index >> pflr_pkg::OFFSET_BITS);
  assign offset = s1_index[pflr_pkg::OFFSET_BITS-1:0];

  pflr_frame_table #(
    .FRAME_COUNT      (FRAME_COUNT),
    .PAGE_NUMBER_BITS (PAGE_NUMBER_BITS)
  ) u_table (
    .clk         (clk),
    .rst         (rst),
    .update      (advance),
    .page        (page),
    .victim_slot (victim_slot),
    .lookup      (lookup),
    .slot        (slot),
    .valid_mask  (valid_mask)
  );

  pflr_victim_pick #(
    .FRAME_COUNT (FRAME_COUNT)
  ) u_victim (
    .clk  (clk),
    .rst  (rst),
    .step (advance && lookup.use_victim),
    .slot (victim_slot)
  );

  pflr_sat_counter u_hits (
    .clk        (clk),
    .rst        (rst),
    .inc        (advance && lookup.hit),
    .count      (hit_count),
    .count_next (hit_count_next)
  );

  pflr_sat_counter u_faults (
    .clk        (clk),
    .rst        (rst),
    .inc        (advance && !lookup.hit),
    .count      (fault_count),
    .count_next (fault_count_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_slot   <= pflr_pkg::SLOT_OUT_BITS'(slot);
      out_offset <= offset;
      out_hit    <= lookup.hit;
      out_fetch  <= lookup.hit ? '0 : pflr_pkg::FETCH_BITS'(page);
      out_hits   <= hit_count_next;
      out_faults <= fault_count_next;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.frame_slot  = out_slot;
  assign rsp.page_offset = out_offset;
  assign rsp.was_hit     = out_hit;
  assign rsp.fetch_page  = out_fetch;
  assign rsp.hit_total   = out_hits;
  assign rsp.fault_total = out_faults;

  // Checks on the block's own logic.
  a_hit_no_fetch : assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.was_hit |-> rsp.fetch_page == '0)
    else $error("fetch page is not zero on a hit");

  a_frames_stay_loaded : assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (valid_mask & $past(valid_mask)) == $past(valid_mask))
    else $error("a loaded frame lost its flag without reset");

  a_hits_monotonic : assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> hit_count >= $past(hit_count))
    else $error("hit counter went down");

  a_faults_monotonic : assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> fault_count >= $past(fault_count))
    else $error("fault counter went down");

  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> s1_valid && out_valid && !rsp.ready)
    else $error("request side stalled without a blocked result");

endmodule

`default_nettype wire
